### rtl/zigzag_varint_delta_point_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// zigzag varint delta point decoder - assertion macros
// shared concurrent assertion forms for the decoder rtl
// ----------------------------------------------------------------------------
`ifndef ZIGZAG_VARINT_DELTA_POINT_DECODER_CORE_MACROS_SVH
`define ZIGZAG_VARINT_DELTA_POINT_DECODER_CORE_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define ZVDP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("zvdp assertion failed");

// next-cycle implication, held off while reset is asserted
`define ZVDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("zvdp assertion failed");

`endif

### rtl/zvdp_pkg.sv
// ----------------------------------------------------------------------------
// zvdp_pkg
// types, constants and helpers of the zigzag varint delta point decoder
// ----------------------------------------------------------------------------
package zvdp_pkg;

	localparam int MAX_POINTS_DEF = 4096;

	// varint byte layout
	localparam logic [7:0] DATA_MASK   = 8'h7F;
	localparam logic [7:0] MORE_BIT    = 8'h80;
	localparam int         GROUP_SHIFT = 7;
	localparam int         MAX_SHIFT   = 28;
	localparam int         MAX_GROUPS  = 5;

	// result kinds
	localparam logic KIND_POINT   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// stop reasons
	localparam logic [1:0] STOP_NORMAL   = 2'd0;
	localparam logic [1:0] STOP_OVERLONG = 2'd1;
	localparam logic [1:0] STOP_RAN_OUT  = 2'd2;

	// result queue
	localparam int QDEPTH = 4;

	typedef struct packed {
		logic              result_kind;
		logic [11:0]       point_index;
		logic signed [31:0] lat_e6;
		logic signed [31:0] lon_e6;
		logic [12:0]       point_count;
		logic              route_valid;
		logic [1:0]        stop_reason;
		logic              last;
	} result_t;

	function automatic logic [31:0] unzig(input logic [31:0] v);
		unzig = (v >> 1) ^ {32{v[0]}};
	endfunction

endpackage

### rtl/zigzag_varint_delta_point_decoder_core.sv
// ----------------------------------------------------------------------------
// zigzag_varint_delta_point_decoder_core
// route stream byte decoder: base-128 varints, zigzag deltas, running sums
// ----------------------------------------------------------------------------
// Takes one route byte per clock while in_stall is low. A byte is decoded in
// the cycle it is accepted and its results (a point when it closes a lat/lon
// pair, and the end-of-route summary when it is marked last) are written into
// a four-entry result queue and offered from its head in order. Results leave
// one per cycle while out_stall is low; a byte that gives both a point and a
// summary writes both, point first. The input is stalled while the queue has
// fewer than two free slots, so the sustained rate is one byte per cycle
// whenever the output side keeps up. The point limit register may be written
// at any time and takes effect for the next byte.
`include "zigzag_varint_delta_point_decoder_core_macros.svh"

module zigzag_varint_delta_point_decoder_core
	import zvdp_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [12:0]        cfg_data,
	// byte stream
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               is_last,
	// results
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [11:0]        point_index,
	output logic signed [31:0] lat_e6,
	output logic signed [31:0] lon_e6,
	output logic [12:0]        point_count,
	output logic               route_valid,
	output logic [1:0]         stop_reason,
	output logic               last
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int LIM_W = (CNT_W > 13) ? CNT_W : 13;
	localparam int QPW   = $clog2(QDEPTH);
	localparam int QCW   = QPW + 1;

	// configuration register
	logic [12:0]      expected_q;

	// decode state
	logic [31:0]      partial_q;
	logic [2:0]       group_q;
	logic             second_q;
	logic [31:0]      held_q;
	logic [31:0]      lat_q;
	logic [31:0]      lon_q;
	logic [CNT_W-1:0] done_q;
	logic             halted_q;
	logic [1:0]       cause_q;

	// result queue
	result_t          queue_q [QDEPTH];
	logic [QPW-1:0]   rd_q;
	logic [QPW-1:0]   wr_q;
	logic [QCW-1:0]   count_q;

	logic             in_acc;
	logic             out_acc;
	logic [LIM_W-1:0] limit;
	logic [5:0]       shift_amt;
	logic [31:0]      merged;
	logic             more;

	logic [31:0]      n_partial;
	logic [2:0]       n_group;
	logic             n_second;
	logic [31:0]      n_held;
	logic [31:0]      n_lat;
	logic [31:0]      n_lon;
	logic [CNT_W-1:0] n_done;
	logic             n_halted;
	logic [1:0]       n_cause;
	logic             pt_emit;
	logic [1:0]       sum_reason;
	result_t          pt_res;
	result_t          sum_res;
	logic [QPW-1:0]   wr_next;
	logic [QCW-1:0]   n_wr;

	assign cfg_ready = 1'b1;
	assign in_stall  = count_q > QCW'(QDEPTH - 2);
	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = count_q != '0;
	assign out_acc   = out_valid & ~out_stall;

	assign limit = (LIM_W'(expected_q) > LIM_W'(MAX_POINTS)) ?
		LIM_W'(MAX_POINTS) : LIM_W'(expected_q);

	assign shift_amt = 6'(group_q) * 6'(GROUP_SHIFT);
	assign more      = (data_byte & MORE_BIT) != 8'h00;
	assign merged    = (shift_amt <= 6'(MAX_SHIFT)) ?
		(partial_q | (32'(data_byte & DATA_MASK) << shift_amt)) : partial_q;

	always_comb begin
		n_partial = partial_q;
		n_group   = group_q;
		n_second  = second_q;
		n_held    = held_q;
		n_lat     = lat_q;
		n_lon     = lon_q;
		n_done    = done_q;
		n_halted  = halted_q;
		n_cause   = cause_q;
		pt_emit   = 1'b0;

		// limit already met before this byte
		if (!halted_q && (LIM_W'(done_q) >= limit)) begin
			n_halted = 1'b1;
			n_cause  = STOP_NORMAL;
		end

		if (!n_halted) begin
			if (!more) begin
				n_partial = '0;
				n_group   = '0;
				if (!second_q) begin
					n_held   = merged;
					n_second = 1'b1;
				end else begin
					n_second = 1'b0;
					n_lat    = lat_q + unzig(held_q);
					n_lon    = lon_q + unzig(merged);
					pt_emit  = 1'b1;
					n_done   = done_q + CNT_W'(1);
					if (LIM_W'(n_done) >= limit) begin
						n_halted = 1'b1;
						n_cause  = STOP_NORMAL;
					end
				end
			end else begin
				n_partial = merged;
				n_group   = group_q + 3'd1;
				if (n_group >= 3'(MAX_GROUPS)) begin
					n_halted = 1'b1;
					n_cause  = STOP_OVERLONG;
				end
			end
		end

		priority if (n_halted) begin
			sum_reason = n_cause;
		end else if (n_group != '0 || n_second) begin
			sum_reason = STOP_RAN_OUT;
		end else begin
			sum_reason = STOP_NORMAL;
		end
	end

	always_comb begin
		pt_res.result_kind = KIND_POINT;
		pt_res.point_index = 12'(done_q);
		pt_res.lat_e6      = $signed(n_lat);
		pt_res.lon_e6      = $signed(n_lon);
		pt_res.point_count = '0;
		pt_res.route_valid = 1'b0;
		pt_res.stop_reason = STOP_NORMAL;
		pt_res.last        = 1'b0;

		sum_res.result_kind = KIND_SUMMARY;
		sum_res.point_index = '0;
		sum_res.lat_e6      = $signed(n_lat);
		sum_res.lon_e6      = $signed(n_lon);
		sum_res.point_count = 13'(n_done);
		sum_res.route_valid = n_done >= CNT_W'(2);
		sum_res.stop_reason = sum_reason;
		sum_res.last        = 1'b1;
	end

	assign wr_next = wr_q + QPW'(1);
	assign n_wr    = in_acc ? (QCW'(pt_emit) + QCW'(is_last)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= 13'd1;
		end else if (cfg_valid && cfg_ready) begin
			expected_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			group_q   <= '0;
			second_q  <= 1'b0;
			held_q    <= '0;
			lat_q     <= '0;
			lon_q     <= '0;
			done_q    <= '0;
			halted_q  <= 1'b0;
			cause_q   <= STOP_NORMAL;
		end else if (in_acc) begin
			if (is_last) begin
				// summary given, next byte opens a new route
				partial_q <= '0;
				group_q   <= '0;
				second_q  <= 1'b0;
				held_q    <= '0;
				lat_q     <= '0;
				lon_q     <= '0;
				done_q    <= '0;
				halted_q  <= 1'b0;
				cause_q   <= STOP_NORMAL;
			end else begin
				partial_q <= n_partial;
				group_q   <= n_group;
				second_q  <= n_second;
				held_q    <= n_held;
				lat_q     <= n_lat;
				lon_q     <= n_lon;
				done_q    <= n_done;
				halted_q  <= n_halted;
				cause_q   <= n_cause;
			end
		end
	end

	// queue storage, payload only
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (pt_emit) begin
				queue_q[wr_q] <= pt_res;
				if (is_last) begin
					queue_q[wr_next] <= sum_res;
				end
			end else if (is_last) begin
				queue_q[wr_q] <= sum_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPW'(n_wr);
			rd_q    <= rd_q + QPW'(out_acc);
			count_q <= count_q + n_wr - QCW'(out_acc);
		end
	end

	assign result_kind = queue_q[rd_q].result_kind;
	assign point_index = queue_q[rd_q].point_index;
	assign lat_e6      = queue_q[rd_q].lat_e6;
	assign lon_e6      = queue_q[rd_q].lon_e6;
	assign point_count = queue_q[rd_q].point_count;
	assign route_valid = queue_q[rd_q].route_valid;
	assign stop_reason = queue_q[rd_q].stop_reason;
	assign last        = queue_q[rd_q].last;

	`ZVDP_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, count_q <= QCW'(QDEPTH))
	`ZVDP_ASSERT_NOW(a_run_group, clk, arst_n, !halted_q, group_q < 3'(MAX_GROUPS))
	`ZVDP_ASSERT_NOW(a_overlong_group, clk, arst_n,
		halted_q && cause_q == STOP_OVERLONG, group_q == 3'(MAX_GROUPS))
	`ZVDP_ASSERT_NEXT(a_route_cleared, clk, arst_n, in_acc && is_last,
		done_q == '0 && group_q == '0 && !second_q && !halted_q)

endmodule

### dv/tb_zigzag_varint_delta_point_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zigzag_varint_delta_point_decoder_core
// drives route byte streams into the decoder and checks every point and
// summary beat against a cycle-free model of the varint/zigzag decoding
// ----------------------------------------------------------------------------
module tb_zigzag_varint_delta_point_decoder_core;
	import zvdp_pkg::*;

	localparam logic [12:0] ROUTE_CAP = 13'(MAX_POINTS_DEF);

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [12:0] cfg_data = '0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic is_last = 1'b0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic [11:0] point_index;
	logic signed [31:0] lat_e6;
	logic signed [31:0] lon_e6;
	logic [12:0] point_count;
	logic route_valid;
	logic [1:0] stop_reason;
	logic last;

	zigzag_varint_delta_point_decoder_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.point_index (point_index),
		.lat_e6      (lat_e6),
		.lon_e6      (lon_e6),
		.point_count (point_count),
		.route_valid (route_valid),
		.stop_reason (stop_reason),
		.last        (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// decoder model state
	logic [12:0] limit_reg = 13'd1;
	logic [31:0] acc_value = '0;
	logic [2:0]  group_cnt = '0;
	logic        on_lon = 1'b0;
	logic [31:0] lat_code = '0;
	logic [31:0] lat_sum = '0;
	logic [31:0] lon_sum = '0;
	logic [12:0] points_done = '0;
	logic        halted = 1'b0;
	logic [1:0]  halt_cause = STOP_NORMAL;

	result_t due_results[$];
	logic [7:0] route_bytes[$];

	int n_errors = 0;
	int bytes_sent = 0;
	int burst_left = 0;
	int max_gap = 0;
	int stall_pct = 0;
	int stall_left = 0;

	function automatic logic [31:0] zz_delta(input logic [31:0] code);
		return {1'b0, code[31:1]} ^ (32'd0 - {31'd0, code[0]});
	endfunction

	task automatic decode_route_byte(input logic [7:0] b, input logic lst);
		logic [12:0] lim;
		logic [31:0] v;
		result_t r;
		lim = (limit_reg > ROUTE_CAP) ? ROUTE_CAP : limit_reg;
		if (!halted && points_done >= lim) begin
			halted = 1'b1;
			halt_cause = STOP_NORMAL;
		end
		if (!halted) begin
			// bits past bit 31 of a fifth group fall off here
			acc_value = acc_value | (32'(b & DATA_MASK) << (group_cnt * GROUP_SHIFT));
			if ((b & MORE_BIT) == 8'd0) begin
				v = acc_value;
				acc_value = '0;
				group_cnt = '0;
				if (!on_lon) begin
					lat_code = v;
					on_lon = 1'b1;
				end else begin
					on_lon = 1'b0;
					lat_sum = lat_sum + zz_delta(lat_code);
					lon_sum = lon_sum + zz_delta(v);
					r = '0;
					r.result_kind = KIND_POINT;
					r.point_index = points_done[11:0];
					r.lat_e6 = lat_sum;
					r.lon_e6 = lon_sum;
					due_results.push_back(r);
					points_done = points_done + 13'd1;
					if (points_done >= lim) begin
						halted = 1'b1;
						halt_cause = STOP_NORMAL;
					end
				end
			end else begin
				group_cnt = group_cnt + 3'd1;
				if (group_cnt >= MAX_GROUPS) begin
					halted = 1'b1;
					halt_cause = STOP_OVERLONG;
				end
			end
		end
		if (lst) begin
			r = '0;
			r.result_kind = KIND_SUMMARY;
			r.lat_e6 = lat_sum;
			r.lon_e6 = lon_sum;
			r.point_count = points_done;
			r.route_valid = (points_done >= 13'd2);
			if (halted)
				r.stop_reason = halt_cause;
			else if (group_cnt != 0 || on_lon)
				r.stop_reason = STOP_RAN_OUT;
			else
				r.stop_reason = STOP_NORMAL;
			r.last = 1'b1;
			due_results.push_back(r);
			acc_value = '0;
			group_cnt = '0;
			on_lon = 1'b0;
			lat_code = '0;
			lat_sum = '0;
			lon_sum = '0;
			points_done = '0;
			halted = 1'b0;
			halt_cause = STOP_NORMAL;
		end
	endtask

	// receiver stall pattern: runs of stall / no stall of random length
	always @(negedge clk) begin
		if (stall_left == 0) begin
			out_stall <= ($urandom_range(99) < stall_pct);
			stall_left = $urandom_range(1, 8);
		end else begin
			stall_left--;
		end
	end

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			n_errors++;
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				n_errors++;
				$display("%0t ns: unexpected beat, expected none actual kind %0d idx %0d",
					$time, result_kind, point_index);
			end else begin
				want = due_results.pop_front();
				check_field("result_kind", want.result_kind, result_kind);
				check_field("point_index", want.point_index, point_index);
				check_field("lat_e6", want.lat_e6, lat_e6);
				check_field("lon_e6", want.lon_e6, lon_e6);
				check_field("point_count", want.point_count, point_count);
				check_field("route_valid", want.route_valid, route_valid);
				check_field("stop_reason", want.stop_reason, stop_reason);
				check_field("last", want.last, last);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		is_last <= lst;
		do @(posedge clk); while (in_stall);
		decode_route_byte(b, lst);
		bytes_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, max_gap);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				data_byte <= 8'($urandom);
				is_last <= 1'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// hold the sender off until every due beat is out and the pipe is quiet
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_point_limit(input logic [12:0] v);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		limit_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data <= 13'($urandom);
	endtask

	// send the queued bytes; close marks the final one as end of route
	task automatic send_route(input bit close);
		int i;
		for (i = 0; i < route_bytes.size(); i++)
			send_byte(route_bytes[i], close && (i == route_bytes.size() - 1));
		route_bytes.delete();
	endtask

	task automatic add_varint(input int nbytes);
		int i;
		for (i = 0; i < nbytes; i++)
			route_bytes.push_back({(i < nbytes - 1), 7'($urandom)});
	endtask

	task automatic test_extreme_deltas();
		write_point_limit(13'd2);
		// most negative then most positive delta, both in five groups, the first with excess bits
		route_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
			8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h01, 8'h02};
		send_route(1'b1);
	endtask

	task automatic test_zero_limit();
		write_point_limit(13'd0);
		route_bytes = '{8'h02, 8'h04};
		send_route(1'b1);
	endtask

	task automatic test_overlong_varint();
		write_point_limit(13'h1FFF);
		route_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00};
		send_route(1'b1);
	endtask

	task automatic test_ran_out();
		route_bytes = '{8'h81};
		send_route(1'b1);
		route_bytes = '{8'h02};
		send_route(1'b1);
	endtask

	task automatic test_midroute_limit();
		write_point_limit(13'd50);
		route_bytes = '{8'h02, 8'h03};
		send_route(1'b0);
		write_point_limit(13'd1);
		route_bytes = '{8'h05};
		send_route(1'b1);
	endtask

	task automatic test_random_routes();
		int npairs;
		int i;
		int shape;
		int len;
		while (bytes_sent < 820) begin
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(9))
					0: write_point_limit(13'd0);
					1: write_point_limit(13'h1FFF);
					2: write_point_limit(ROUTE_CAP);
					3: write_point_limit(13'($urandom));
					default: write_point_limit(13'($urandom_range(1, 12)));
				endcase
			end
			stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 70);
			max_gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			npairs = $urandom_range(0, 12);
			for (i = 0; i < 2 * npairs; i++) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : $urandom_range(1, 2);
				add_varint(len);
			end
			shape = $urandom_range(9);
			if (shape == 0 && route_bytes.size() > 0) begin
				// cut the route short, possibly inside a varint
				len = $urandom_range(1, route_bytes.size());
				repeat (len) void'(route_bytes.pop_back());
			end else if (shape == 1) begin
				repeat (5) route_bytes.push_back(8'h80 | 8'($urandom));
				repeat ($urandom_range(0, 4)) route_bytes.push_back(8'($urandom));
			end else if (shape == 2) begin
				repeat ($urandom_range(1, 10)) route_bytes.push_back(8'($urandom));
			end
			if (route_bytes.size() == 0)
				route_bytes.push_back(8'($urandom));
			send_route(1'b1);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		stall_pct = 30;
		max_gap = 3;
		test_extreme_deltas();
		test_zero_limit();
		test_overlong_varint();
		test_ran_out();
		test_midroute_limit();
		test_random_routes();
		wait_idle();
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/zvdp_pkg.sv
rtl/zigzag_varint_delta_point_decoder_core.sv
dv/tb_zigzag_varint_delta_point_decoder_core.sv
